// ===== design/midi_note_pair_matcher_macros.svh =====
// Assertion macros used by the note pairing RTL.
`ifndef MIDI_NOTE_PAIR_MATCHER_MACROS_SVH
`define MIDI_NOTE_PAIR_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MNPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MNPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mnpm_pkg.sv =====
// Shared types and constants of the note on/off pairing block.
package mnpm_pkg;

  localparam int STACK_DEPTH_DEF = 4;
  localparam int NUM_KEYS_DEF    = 128;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_DROPPED   = 2'd2
  } status_t;

  // One open note: start tick, channel, velocity (43 bits).
  typedef struct packed {
    logic [31:0] start;
    logic [3:0]  chan;
    logic [6:0]  vel;
  } entry_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    cnt_wr;
    logic    cnt_up;
    logic    store_wr;
    logic    store_rd;
    logic    load_result;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic is_on;
    logic key_ok;
    logic empty;
    logic full;
  } sts_t;

endpackage

// ===== design/mnpm_if.sv =====
// Event input and note result channel interfaces.
interface mnpm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] event_time;
  logic [3:0]  channel;
  logic [6:0]  note_key;
  logic [6:0]  velocity;

  modport source (output valid, req_type, event_time, channel, note_key, velocity,
                  input ready);
  modport sink (input valid, req_type, event_time, channel, note_key, velocity,
                output ready);
endinterface

interface mnpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [3:0]  note_channel;
  logic [6:0]  out_key;
  logic [6:0]  note_velocity;

  modport source (output valid, status, start_time, end_time, note_channel, out_key,
                  note_velocity, input ready);
  modport sink (input valid, status, start_time, end_time, note_channel, out_key,
                note_velocity, output ready);
endinterface

// ===== design/mnpm_ctrl.sv =====
// Sequencing FSM: accept, count lookup, stack read, result hand-off.
`include "midi_note_pair_matcher_macros.svh"

module mnpm_ctrl
  import mnpm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CNT,
    S_RD,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;

  always_comb begin
    cmd            = '0;
    cmd.res_status = res_status_r;
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CNT;
        end
      end
      S_CNT: begin
        if (sts.is_on) begin
          if (!sts.key_ok || sts.full) begin
            res_status_nxt = ST_DROPPED;
            state_nxt      = S_EMIT;
          end else begin
            cmd.store_wr = 1'b1;
            cmd.cnt_wr   = 1'b1;
            cmd.cnt_up   = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          if (!sts.key_ok || sts.empty) begin
            res_status_nxt = ST_UNMATCHED;
            state_nxt      = S_EMIT;
          end else begin
            // pop: read top entry, count goes down
            cmd.store_rd   = 1'b1;
            cmd.cnt_wr     = 1'b1;
            res_status_nxt = ST_DONE;
            state_nxt      = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_DONE;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  `MNPM_ASSERT_NXT(a_accept_to_cnt, (state_r == S_IDLE) && sts.in_valid, state_r == S_CNT, "accepted word did not reach count lookup")
  `MNPM_ASSERT_IMP(a_pop_nonempty, cmd.store_rd, !sts.empty && sts.key_ok && !sts.is_on, "pop from empty or invalid stack")
  `MNPM_ASSERT_IMP(a_push_room, cmd.store_wr, !sts.full && sts.key_ok && sts.is_on, "push onto full or invalid stack")
  `MNPM_ASSERT_IMP(a_load_free, cmd.load_result, sts.out_free, "result loaded over a waiting word")

endmodule

// ===== design/mnpm_dp.sv =====
// Datapath: event capture, per-key counts, open-note stacks, result register.
module mnpm_dp
  import mnpm_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_KEYS    = NUM_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mnpm_in_if.sink    in_ch,
  mnpm_out_if.source out_ch,
  input  cmd_t       cmd,
  output sts_t       sts
);

  localparam int CW      = $clog2(STACK_DEPTH + 1);
  localparam int SW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int KW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ENTRIES = NUM_KEYS * STACK_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // captured event
  logic          is_on_r;
  logic          key_ok_r;
  logic [31:0]   time_r;
  logic [3:0]    chan_r;
  logic [6:0]    key_r;
  logic [6:0]    vel_r;
  logic [KW-1:0] key_idx_r;

  // per-key counts; a key whose valid bit is clear reads as empty
  logic [CW-1:0]       cnt_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] cnt_vld_r;
  logic [CW-1:0]       cnt_rd_r;
  logic                cnt_hit_r;

  entry_t store_mem [ENTRIES];
  entry_t store_rd_r;

  // result word
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_start_r;
  logic [31:0] out_end_r;
  logic [3:0]  out_chan_r;
  logic [6:0]  out_key_r;
  logic [6:0]  out_vel_r;

  logic          in_key_ok;
  logic [KW-1:0] in_key_idx;
  logic [CW-1:0] cnt_n;
  logic [SW-1:0] stk_idx;
  logic [AW-1:0] store_addr;
  entry_t        wr_entry;

  assign in_key_ok  = 9'(in_ch.note_key) < 9'(NUM_KEYS);
  assign in_key_idx = in_key_ok ? KW'(in_ch.note_key) : '0;

  assign cnt_n      = cnt_hit_r ? cnt_rd_r : '0;
  assign stk_idx    = cmd.cnt_up ? SW'(cnt_n) : SW'(cnt_n - CW'(1));
  assign store_addr = AW'(AW'(key_idx_r) * AW'(STACK_DEPTH)) + AW'(stk_idx);

  assign wr_entry.start = time_r;
  assign wr_entry.chan  = chan_r;
  assign wr_entry.vel   = vel_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_on_r   <= in_ch.req_type && (in_ch.velocity != 7'd0);
      key_ok_r  <= in_key_ok;
      time_r    <= in_ch.event_time;
      chan_r    <= in_ch.channel;
      key_r     <= in_ch.note_key;
      vel_r     <= in_ch.velocity;
      key_idx_r <= in_key_idx;
      cnt_rd_r  <= cnt_mem[in_key_idx];
      cnt_hit_r <= cnt_vld_r[in_key_idx];
    end
    if (cmd.cnt_wr) begin
      cnt_mem[key_idx_r] <= cmd.cnt_up ? CW'(cnt_n + CW'(1)) : CW'(cnt_n - CW'(1));
    end
    if (cmd.store_wr) begin
      store_mem[store_addr] <= wr_entry;
    end
    if (cmd.store_rd) begin
      store_rd_r <= store_mem[store_addr];
    end
    if (cmd.load_result) begin
      out_status_r <= cmd.res_status;
      out_key_r    <= key_r;
      if (cmd.res_status == ST_DONE) begin
        out_start_r <= store_rd_r.start;
        out_end_r   <= time_r;
        out_chan_r  <= store_rd_r.chan;
        out_vel_r   <= store_rd_r.vel;
      end else begin
        out_start_r <= '0;
        out_end_r   <= '0;
        out_chan_r  <= '0;
        out_vel_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_wr) begin
        cnt_vld_r[key_idx_r] <= 1'b1;
      end
      if (cmd.load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_valid = in_ch.valid;
  assign sts.out_free = !out_valid_r || out_ch.ready;
  assign sts.is_on    = is_on_r;
  assign sts.key_ok   = key_ok_r;
  assign sts.empty    = (cnt_n == '0);
  assign sts.full     = (cnt_n >= CW'(STACK_DEPTH));

  assign in_ch.ready          = cmd.in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.start_time    = out_start_r;
  assign out_ch.end_time      = out_end_r;
  assign out_ch.note_channel  = out_chan_r;
  assign out_ch.out_key       = out_key_r;
  assign out_ch.note_velocity = out_vel_r;

endmodule

// ===== design/midi_note_pair_matcher.sv =====
// Top level of the MIDI note on/off pairing block (per-key LIFO of open notes).
// Each event is captured and its count looked up; a stored note on ends there,
// a dropped on or unmatched off loads the result register and a matched off
// reads the stack first; a waiting result word stalls only the next result.
// Reset clears the FSM, the per-key count valid bits and the result valid.
module midi_note_pair_matcher
  import mnpm_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_KEYS    = NUM_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mnpm_in_if.sink    in_ch,
  mnpm_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  mnpm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  mnpm_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_KEYS    (NUM_KEYS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
